### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned POS_W = 9;

  localparam logic [7:0]       ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0]       FLIP_MASK   = 8'h20;
  localparam logic [POS_W-1:0] POS_FIRST   = 9'd1;
  localparam logic [POS_W-1:0] POS_SUM     = 9'd2;
  localparam logic [POS_W-1:0] POS_STATE   = 9'd3;
  localparam logic [POS_W-1:0] POS_LENGTH  = 9'd4;
  localparam logic [POS_W-1:0] DATA_START  = 9'd5;
  localparam logic [POS_W-1:0] POS_MAX     = 9'd511;

  // Unstuffed byte or stop marker, passed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       stop;
  } sfd_item_t;

  // Result payload held in the output register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic [7:0] device_state;
    logic [7:0] reported_length;
    logic       checksum_bad;
  } sfd_result_t;

endpackage

### rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready channels for raw frame bytes and for deframer results.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [7:0] device_state;
  logic [7:0] reported_length;
  logic       checksum_bad;

  modport source (output valid, output data_byte, output frame_end, output device_state,
                  output reported_length, output checksum_bad, input ready);
  modport sink   (input valid, input data_byte, input frame_end, input device_state,
                  input reported_length, input checksum_bad, output ready);
endinterface

### rtl/shdlc_frame_deframer.sv
// ----------------------------------------------------------------------------
// shdlc_frame_deframer
// Receive-side deframer for stuffed SHDLC-style reply frames.
// ----------------------------------------------------------------------------
// in_ch carries one raw byte per transfer; end_of_frame marks the stop byte.
// The first byte of a frame is dropped, 0x7D escapes are removed and the
// following byte has bit 5 flipped. out_ch gives one transfer per payload
// byte within the declared length (frame_end = 0) and one status transfer
// per frame on the stop byte (frame_end = 1) with device state, length and
// checksum flag.
// Throughput is one input byte per cycle while the queue has room. The front
// stage unstuffs into a FIFO_DEPTH-entry queue; the back stage pops it and
// loads the output register. A status result goes through the queue and the
// output register; a payload byte is emitted when the next byte is popped.
// When out_ch stalls, the output register holds, the queue fills and
// in_ch.ready drops once it is full. Reset (rst_n low, synchronous) empties
// the queue and output register and starts a new frame.
// ----------------------------------------------------------------------------
module shdlc_frame_deframer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);

  logic               push_valid;
  sfd_pkg::sfd_item_t push_item;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  sfd_pkg::sfd_item_t q_item;

  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  sfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  sfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts raw bytes, skips the start byte and removes byte stuffing.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  sfd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push_valid,
  output sfd_pkg::sfd_item_t push_item
);

  logic started_r, started_nxt;
  logic esc_r, esc_nxt;
  logic acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    started_nxt    = started_r;
    esc_nxt        = esc_r;
    push_valid     = 1'b0;
    push_item.data = in_ch.rx_byte;
    push_item.stop = 1'b0;
    if (acc) begin
      if (in_ch.end_of_frame) begin
        push_valid     = 1'b1;
        push_item.stop = 1'b1;
        started_nxt    = 1'b0;
        esc_nxt        = 1'b0;
      end else if (!started_r) begin
        started_nxt = 1'b1;
      end else if (!esc_r && in_ch.rx_byte == sfd_pkg::ESCAPE_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        push_valid = 1'b1;
        if (esc_r) begin
          push_item.data = in_ch.rx_byte ^ sfd_pkg::FLIP_MASK;
        end
        esc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      esc_r     <= 1'b0;
    end else begin
      started_r <= started_nxt;
      esc_r     <= esc_nxt;
    end
  end

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.end_of_frame) |=> (!started_r && !esc_r))
    else $error("front state not cleared after stop byte");

  a_no_escape_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> started_r)
    else $error("escape pending outside a frame");

endmodule

### rtl/sfd_fifo.sv
// ----------------------------------------------------------------------------
// sfd_fifo
// Short queue of unstuffed items between front and back.
// ----------------------------------------------------------------------------
module sfd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfd_pkg::sfd_item_t push_item,
  input  logic               pop,
  output sfd_pkg::sfd_item_t pop_item,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfd_pkg::sfd_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_FULL);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

endmodule

### rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Tracks frame position and checksum, emits payload bytes and frame status.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sfd_pkg::sfd_item_t q_item,
  output logic               q_pop,
  sfd_out_if.source          out_ch
);

  logic [sfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] len_r, len_nxt;
  logic       out_valid_r, out_valid_nxt;
  sfd_pkg::sfd_result_t res_r, res_nxt;
  logic [sfd_pkg::POS_W-1:0] data_idx;
  logic       emit;

  assign q_pop    = !q_empty && (!out_valid_r || out_ch.ready);
  // Index of prev_r within the payload, valid once pos_r passes the header.
  assign data_idx = pos_r - (sfd_pkg::DATA_START + sfd_pkg::POS_FIRST);

  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    dev_nxt       = dev_r;
    len_nxt       = len_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    emit          = 1'b0;
    if (q_pop) begin
      if (q_item.stop) begin
        res_nxt.data_byte       = 8'h00;
        res_nxt.frame_end       = 1'b1;
        res_nxt.device_state    = dev_r;
        res_nxt.reported_length = len_r;
        res_nxt.checksum_bad    = (prev_r != ~sum_r);
        out_valid_nxt           = 1'b1;
        pos_nxt                 = sfd_pkg::POS_FIRST;
        sum_nxt                 = 8'h00;
        prev_nxt                = 8'h00;
        dev_nxt                 = 8'h00;
        len_nxt                 = 8'h00;
      end else begin
        if (pos_r >= sfd_pkg::POS_SUM) begin
          sum_nxt = sum_r + prev_r;
          emit    = (pos_r >= sfd_pkg::DATA_START + sfd_pkg::POS_FIRST) &&
                    (data_idx < {1'b0, len_r});
        end
        if (emit) begin
          res_nxt.data_byte       = prev_r;
          res_nxt.frame_end       = 1'b0;
          res_nxt.device_state    = 8'h00;
          res_nxt.reported_length = 8'h00;
          res_nxt.checksum_bad    = 1'b0;
          out_valid_nxt           = 1'b1;
        end
        prev_nxt = q_item.data;
        if (pos_r == sfd_pkg::POS_STATE) begin
          dev_nxt = q_item.data;
        end else if (pos_r == sfd_pkg::POS_LENGTH) begin
          len_nxt = q_item.data;
        end
        if (pos_r < sfd_pkg::POS_MAX) begin
          pos_nxt = pos_r + sfd_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= sfd_pkg::POS_FIRST;
      sum_r       <= 8'h00;
      prev_r      <= 8'h00;
      dev_r       <= 8'h00;
      len_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      dev_r       <= dev_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.data_byte       = res_r.data_byte;
  assign out_ch.frame_end       = res_r.frame_end;
  assign out_ch.device_state    = res_r.device_state;
  assign out_ch.reported_length = res_r.reported_length;
  assign out_ch.checksum_bad    = res_r.checksum_bad;

  a_stop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.stop) |=> (pos_r == sfd_pkg::POS_FIRST && sum_r == 8'h00 && out_valid_r))
    else $error("frame state not reset after stop item");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '0)
    else $error("position counter wrapped");

endmodule
